FILE: rtl/dlsd_pkg.sv
// ----------------------------------------------------------------------------
// dlsd_pkg
// Shared types and constants for the dose log stream decoder: the input and
// result word layouts, the leader codes of the log format and the interval
// lookup for absolute entries.
// ----------------------------------------------------------------------------
package dlsd_pkg;

	// One word of the log byte stream.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       skip_empty;
	} dlsd_in_t;

	// One decoded record, or an end-of-data marker.
	typedef struct packed {
		logic [31:0] record_time;
		logic [31:0] pulse_count;
		logic        session_start;
		logic        end_of_data;
	} dlsd_out_t;

	// Leader codes and masks of the log format.
	localparam logic [7:0] LEAD_TWO_BYTE   = 8'h80;
	localparam logic [7:0] LEAD_THREE_BYTE = 8'hC0;
	localparam logic [7:0] LEAD_FOUR_BYTE  = 8'hE0;
	localparam logic [7:0] LEAD_FIVE_BYTE  = 8'hF0;
	localparam logic [7:0] LEAD_ABS_FIRST  = 8'hF1;
	localparam logic [7:0] LEAD_ABS_LAST   = 8'hF5;
	localparam logic [7:0] LEAD_SESSION    = 8'hF8;
	localparam logic [7:0] LEAD_EMPTY      = 8'hFF;
	localparam logic [7:0] MASK_TWO_BYTE   = 8'h3F;

	// Interval lengths in seconds for the absolute entry leaders.
	localparam int INTERVAL_W = 12;
	localparam logic [INTERVAL_W-1:0] IVL_HOUR       = INTERVAL_W'(60 * 60);
	localparam logic [INTERVAL_W-1:0] IVL_TEN_MIN    = INTERVAL_W'(10 * 60);
	localparam logic [INTERVAL_W-1:0] IVL_MINUTE     = INTERVAL_W'(1 * 60);
	localparam logic [INTERVAL_W-1:0] IVL_TEN_SEC    = INTERVAL_W'(10);
	localparam logic [INTERVAL_W-1:0] IVL_SECOND     = INTERVAL_W'(1);

	// Interval selected by an absolute leader (0xF1 to 0xF5).
	function automatic logic [INTERVAL_W-1:0] interval_of(input logic [7:0] leader);
		logic [INTERVAL_W-1:0] ivl;
		case (leader[2:0])
			3'd1:    ivl = IVL_HOUR;
			3'd2:    ivl = IVL_TEN_MIN;
			3'd3:    ivl = IVL_MINUTE;
			3'd4:    ivl = IVL_TEN_SEC;
			3'd5:    ivl = IVL_SECOND;
			default: ivl = '0;
		endcase
		return ivl;
	endfunction

endpackage

FILE: rtl/dose_log_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// dose_log_stream_decoder_core
// Rebuilds cumulative dose records from a prefix-coded log byte stream.
// ----------------------------------------------------------------------------
// Usage:
// The log channel (log_valid, log_stall, log_word) carries one stream byte
// per word together with the skip_empty flag. The record channel (rec_valid,
// rec_stall, rec_word) returns zero or one result word per input word: a
// record when an entry completes, or an end-of-data marker when 0xFF ends
// the stream and skip_empty is low.
// Each word is captured in an input register, decoded against the running
// state in one pass of short logic, and the result lands in an output
// register. Throughput is one word per cycle; the single output register
// is the only buffer for results, so a word that would produce a result
// waits in the input register while the receiver stalls, and log_stall
// rises with it. Words that complete no entry pass through even while
// the output is held. Reset clears all running sums, the interval and
// any partial entry, and empties both registers; no clearing pass is
// needed afterward.
// ----------------------------------------------------------------------------
module dose_log_stream_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                log_valid,
	output logic                log_stall,
	input  dlsd_pkg::dlsd_in_t  log_word,
	output logic                rec_valid,
	input  logic                rec_stall,
	output dlsd_pkg::dlsd_out_t rec_word
);
	import dlsd_pkg::*;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_INCR,
		KIND_ABS_TIME,
		KIND_ABS_COUNT
	} kind_t;

	// Input register.
	logic     valid_s1;
	dlsd_in_t word_s1;

	// Decoder state.
	kind_t                 kind_q;
	logic [2:0]            remain_q;
	logic [31:0]           asm_q;
	logic [31:0]           time_q;
	logic [31:0]           count_q;
	logic [INTERVAL_W-1:0] ivl_q;
	logic                  session_q;

	// Output register.
	logic      out_valid_q;
	dlsd_out_t out_q;

	// Next-state values.
	kind_t                 kind_d;
	logic [2:0]            remain_d;
	logic [31:0]           asm_d;
	logic [31:0]           time_d;
	logic [31:0]           count_d;
	logic [INTERVAL_W-1:0] ivl_d;
	logic                  session_d;
	logic                  emit;
	dlsd_out_t             result;

	logic        out_free;
	logic        advance;
	logic [7:0]  b;
	logic [31:0] asm_shift;
	logic [2:0]  remain_dec;

	assign b          = word_s1.data_byte;
	assign asm_shift  = {asm_q[23:0], b};
	assign remain_dec = remain_q - 3'd1;

	// Decode one byte against the running state.
	always_comb begin
		kind_d    = kind_q;
		remain_d  = remain_q;
		asm_d     = asm_q;
		time_d    = time_q;
		count_d   = count_q;
		ivl_d     = ivl_q;
		session_d = session_q;
		emit      = 1'b0;
		result    = '0;
		if (kind_q != KIND_IDLE) begin
			asm_d    = asm_shift;
			remain_d = remain_dec;
			if (remain_dec == 3'd0) begin
				case (kind_q)
					KIND_INCR: begin
						kind_d  = KIND_IDLE;
						count_d = count_q + asm_shift;
						time_d  = time_q + 32'(ivl_q);
						emit    = 1'b1;
					end
					KIND_ABS_TIME: begin
						time_d   = asm_shift;
						kind_d   = KIND_ABS_COUNT;
						remain_d = 3'd4;
						asm_d    = '0;
					end
					default: begin
						count_d = asm_shift;
						kind_d  = KIND_IDLE;
						emit    = 1'b1;
					end
				endcase
			end
		end else if (b < LEAD_TWO_BYTE) begin
			count_d = count_q + 32'(b);
			time_d  = time_q + 32'(ivl_q);
			emit    = 1'b1;
		end else if (b < LEAD_THREE_BYTE) begin
			kind_d   = KIND_INCR;
			remain_d = 3'd1;
			asm_d    = 32'(b & MASK_TWO_BYTE);
		end else if (b < LEAD_FOUR_BYTE) begin
			kind_d   = KIND_INCR;
			remain_d = 3'd2;
			asm_d    = 32'(b[4:0]);
		end else if (b < LEAD_FIVE_BYTE) begin
			kind_d   = KIND_INCR;
			remain_d = 3'd3;
			asm_d    = 32'(b[3:0]);
		end else if (b == LEAD_FIVE_BYTE) begin
			kind_d   = KIND_INCR;
			remain_d = 3'd4;
			asm_d    = '0;
		end else if (b >= LEAD_ABS_FIRST && b <= LEAD_ABS_LAST) begin
			ivl_d    = interval_of(b);
			kind_d   = KIND_ABS_TIME;
			remain_d = 3'd4;
			asm_d    = '0;
		end else if (b == LEAD_SESSION) begin
			session_d = 1'b1;
		end else if (b == LEAD_EMPTY && !word_s1.skip_empty) begin
			session_d          = 1'b0;
			result.end_of_data = 1'b1;
			emit               = 1'b1;
		end

		// A completed entry reports the updated sums.
		if (emit && !result.end_of_data) begin
			result.record_time   = time_d;
			result.pulse_count   = count_d;
			result.session_start = session_q;
			session_d            = 1'b0;
		end
	end

	// Handshake: a word leaves the input register unless its result is blocked.
	assign out_free  = !out_valid_q || !rec_stall;
	assign advance   = valid_s1 && (!emit || out_free);
	assign log_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!log_stall) begin
			valid_s1 <= log_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!log_stall && log_valid) begin
			word_s1 <= log_word;
		end
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= KIND_IDLE;
			remain_q  <= '0;
			asm_q     <= '0;
			time_q    <= '0;
			count_q   <= '0;
			ivl_q     <= '0;
			session_q <= 1'b0;
		end else if (advance) begin
			kind_q    <= kind_d;
			remain_q  <= remain_d;
			asm_q     <= asm_d;
			time_q    <= time_d;
			count_q   <= count_d;
			ivl_q     <= ivl_d;
			session_q <= session_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			out_q <= result;
		end
	end

	assign rec_valid = out_valid_q;
	assign rec_word  = out_q;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the dose log stream decoder against its own record predictor. The
// run starts with a short table of hand-picked stream bytes. After that comes
// a long random log made mostly of well-formed entries, with markers, filler
// and stray bytes mixed in. Both channels idle at random, and the record side
// holds off once for a long stretch. Every record word is compared field by
// field with the oldest expected record, hand-typed or predicted.
// ----------------------------------------------------------------------------
module testbench;
	import dlsd_pkg::*;

	// Progress of the entry that the predictor is assembling.
	typedef enum logic [1:0] {
		ENTRY_IDLE,
		ENTRY_INCR,
		ENTRY_ABS_TIME,
		ENTRY_ABS_COUNT
	} entry_kind_e;

	// One stream word to send, with a hand-typed record where it is obvious.
	typedef struct packed {
		dlsd_in_t  word;
		logic      typed;
		dlsd_out_t result;
	} stim_item_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 410;
	localparam int HOLD_OFF_AT   = 150;
	localparam int HOLD_OFF_LEN  = 60;
	localparam int DRAIN_CYCLES  = 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      log_valid = 1'b0;
	logic      log_stall;
	dlsd_in_t  log_word = '0;
	logic      rec_valid;
	logic      rec_stall = 1'b0;
	dlsd_out_t rec_word;

	// Predictor state, starting from the reset values.
	entry_kind_e           entry_kind = ENTRY_IDLE;
	logic [3:0]            bytes_left = '0;
	logic [31:0]           assembly = '0;
	logic [31:0]           time_sum = '0;
	logic [31:0]           count_sum = '0;
	logic [INTERVAL_W-1:0] interval_s = '0;
	logic                  session_pending = 1'b0;

	stim_item_t stream_words [$];
	dlsd_out_t  expected_records [$];
	int         log_words_taken = 0;
	int         failures = 0;

	dose_log_stream_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.log_valid (log_valid),
		.log_stall (log_stall),
		.log_word  (log_word),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_word  (rec_word)
	);

	function automatic stim_item_t word_row(input logic [7:0] b, input logic skip);
		stim_item_t item;
		item = '0;
		item.word.data_byte = b;
		item.word.skip_empty = skip;
		return item;
	endfunction

	function automatic stim_item_t typed_row(input logic [7:0] b, input logic skip,
			input logic [31:0] t, input logic [31:0] c, input logic ss, input logic eod);
		stim_item_t item;
		item = word_row(b, skip);
		item.typed = 1'b1;
		item.result.record_time = t;
		item.result.pulse_count = c;
		item.result.session_start = ss;
		item.result.end_of_data = eod;
		return item;
	endfunction

	// Hand-picked opening stream: extremes, markers inside entries, wraps.
	stim_item_t directed_rows [DIRECTED_ROWS] = '{
		typed_row(8'h00, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0),
		typed_row(8'hFF, 1'b0, 32'h0, 32'h0, 1'b0, 1'b1),
		word_row(8'hFF, 1'b1),
		word_row(8'hF8, 1'b0),
		typed_row(8'h7F, 1'b1, 32'h0, 32'h7F, 1'b1, 1'b0),
		word_row(8'hBF, 1'b0),
		word_row(8'hFF, 1'b1),
		word_row(8'hDF, 1'b1),
		word_row(8'hF8, 1'b0),
		word_row(8'hFF, 1'b0),
		word_row(8'hF0, 1'b0),
		word_row(8'hFF, 1'b0),
		word_row(8'hFF, 1'b1),
		word_row(8'hFF, 1'b0),
		word_row(8'hFF, 1'b1),
		word_row(8'hF5, 1'b1),
		word_row(8'hFF, 1'b0),
		word_row(8'hFF, 1'b1),
		word_row(8'hFF, 1'b0),
		word_row(8'hFF, 1'b1),
		word_row(8'h00, 1'b0),
		word_row(8'h00, 1'b1),
		word_row(8'h00, 1'b0),
		typed_row(8'h00, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0),
		typed_row(8'h01, 1'b0, 32'h0, 32'h1, 1'b0, 1'b0)
	};

	function automatic void add_stream_byte(input logic [7:0] b);
		stream_words.push_back(word_row(b, 1'($urandom_range(0, 1))));
	endfunction

	// Advances the decoder state by one stream word and reports any record.
	task automatic decode_log_word(input dlsd_in_t w, output bit has_record,
			output dlsd_out_t record);
		logic [7:0] b;
		b = w.data_byte;
		has_record = 1'b0;
		record = '0;
		if (entry_kind != ENTRY_IDLE) begin
			assembly = {assembly[23:0], b};
			if (bytes_left != 0)
				bytes_left = bytes_left - 1'b1;
			if (bytes_left == 0) begin
				case (entry_kind)
					ENTRY_INCR: begin
						entry_kind = ENTRY_IDLE;
						count_sum = count_sum + assembly;
						time_sum = time_sum + 32'(interval_s);
						has_record = 1'b1;
					end
					ENTRY_ABS_TIME: begin
						time_sum = assembly;
						entry_kind = ENTRY_ABS_COUNT;
						bytes_left = 4'd4;
						assembly = '0;
					end
					default: begin
						count_sum = assembly;
						entry_kind = ENTRY_IDLE;
						has_record = 1'b1;
					end
				endcase
			end
		end else if (b < LEAD_TWO_BYTE) begin
			count_sum = count_sum + 32'(b);
			time_sum = time_sum + 32'(interval_s);
			has_record = 1'b1;
		end else if (b < LEAD_THREE_BYTE) begin
			entry_kind = ENTRY_INCR;
			bytes_left = 4'd1;
			assembly = 32'(b & MASK_TWO_BYTE);
		end else if (b < LEAD_FOUR_BYTE) begin
			entry_kind = ENTRY_INCR;
			bytes_left = 4'd2;
			assembly = 32'(b[4:0]);
		end else if (b < LEAD_FIVE_BYTE) begin
			entry_kind = ENTRY_INCR;
			bytes_left = 4'd3;
			assembly = 32'(b[3:0]);
		end else if (b == LEAD_FIVE_BYTE) begin
			entry_kind = ENTRY_INCR;
			bytes_left = 4'd4;
			assembly = '0;
		end else if (b <= LEAD_ABS_LAST) begin
			case (b - LEAD_ABS_FIRST)
				8'd0:    interval_s = IVL_HOUR;
				8'd1:    interval_s = IVL_TEN_MIN;
				8'd2:    interval_s = IVL_MINUTE;
				8'd3:    interval_s = IVL_TEN_SEC;
				default: interval_s = IVL_SECOND;
			endcase
			entry_kind = ENTRY_ABS_TIME;
			bytes_left = 4'd4;
			assembly = '0;
		end else if (b == LEAD_SESSION) begin
			session_pending = 1'b1;
		end else if (b == LEAD_EMPTY && !w.skip_empty) begin
			session_pending = 1'b0;
			record.end_of_data = 1'b1;
			has_record = 1'b1;
		end
		// A finished entry reports the sums and consumes the session marker.
		if (has_record && !record.end_of_data) begin
			record.record_time = time_sum;
			record.pulse_count = count_sum;
			record.session_start = session_pending;
			session_pending = 1'b0;
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Predicts on every accepted log word and checks every accepted record word.
	always @(posedge clk) begin
		bit        has_record;
		dlsd_out_t predicted;
		dlsd_out_t want;
		if (arst_n) begin
			if (log_valid && !log_stall) begin
				decode_log_word(log_word, has_record, predicted);
				if (has_record) begin
					if (stream_words[log_words_taken].typed)
						expected_records.push_back(stream_words[log_words_taken].result);
					else
						expected_records.push_back(predicted);
				end
				log_words_taken++;
			end
			if (rec_valid && !rec_stall) begin
				if (expected_records.size() == 0) begin
					$error("record word arrived with no record expected");
					failures++;
				end else begin
					want = expected_records.pop_front();
					if (rec_word.record_time !== want.record_time) begin
						$error("record_time: expected %h, got %h",
							want.record_time, rec_word.record_time);
						failures++;
					end
					if (rec_word.pulse_count !== want.pulse_count) begin
						$error("pulse_count: expected %h, got %h",
							want.pulse_count, rec_word.pulse_count);
						failures++;
					end
					if (rec_word.session_start !== want.session_start) begin
						$error("session_start: expected %b, got %b",
							want.session_start, rec_word.session_start);
						failures++;
					end
					if (rec_word.end_of_data !== want.end_of_data) begin
						$error("end_of_data: expected %b, got %b",
							want.end_of_data, rec_word.end_of_data);
						failures++;
					end
				end
			end
		end
	end

	// Record side: random stall before each word, one long hold-off.
	initial begin
		int unsigned hold;
		bit          calm;
		bit          held_off;
		calm = 1'b0;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
			hold = calm ? 0 : $urandom_range(0, 4);
			if (!held_off && log_words_taken >= HOLD_OFF_AT) begin
				hold = HOLD_OFF_LEN;
				held_off = 1'b1;
			end
			if (hold > 0) begin
				rec_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rec_stall <= 1'b0;
			do @(posedge clk); while (!rec_valid);
		end
	end

	// Builds the stream, releases reset, sends every word and drains.
	initial begin
		int unsigned pick;
		int unsigned n_payload;
		int unsigned taken;
		int unsigned gap;
		logic [7:0]  lead;
		bit          is_filler;
		bit          calm;

		foreach (directed_rows[r])
			stream_words.push_back(directed_rows[r]);

		// Mostly well-formed entries with random content, some noise.
		taken = 0;
		while (taken < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			n_payload = 0;
			is_filler = 1'b0;
			if (pick < 30) begin
				lead = 8'($urandom_range(0, 127));
			end else if (pick < 40) begin
				lead = LEAD_TWO_BYTE | 8'($urandom_range(0, 63));
				n_payload = 1;
			end else if (pick < 48) begin
				lead = LEAD_THREE_BYTE | 8'($urandom_range(0, 31));
				n_payload = 2;
			end else if (pick < 54) begin
				lead = LEAD_FOUR_BYTE | 8'($urandom_range(0, 15));
				n_payload = 3;
			end else if (pick < 60) begin
				lead = LEAD_FIVE_BYTE;
				n_payload = 4;
			end else if (pick < 75) begin
				lead = LEAD_ABS_FIRST + 8'($urandom_range(0, 4));
				n_payload = 8;
			end else if (pick < 82) begin
				lead = LEAD_SESSION;
			end else if (pick < 90) begin
				// Filler codes 0xF6, 0xF7 and 0xF9 to 0xFE.
				gap = $urandom_range(0, 7);
				lead = (gap < 2) ? 8'hF6 + 8'(gap) : 8'hF9 + 8'(gap - 2);
				is_filler = 1'b1;
			end else if (pick < 95) begin
				lead = LEAD_EMPTY;
			end else begin
				lead = 8'($urandom_range(0, 255));
			end
			add_stream_byte(lead);
			repeat (n_payload) begin
				if ($urandom_range(0, 7) == 0)
					add_stream_byte($urandom_range(0, 1) ? 8'hFF : 8'h00);
				else
					add_stream_byte(8'($urandom_range(0, 255)));
			end
			if (!is_filler)
				taken += 1 + n_payload;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Offer each word after a random gap and hold it until taken.
		calm = 1'b0;
		for (int i = 0; i < stream_words.size(); i++) begin
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				log_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			log_valid <= 1'b1;
			log_word <= stream_words[i].word;
			do @(posedge clk); while (log_stall);
		end
		log_valid <= 1'b0;

		@(posedge clk);
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
